// ===== rtl/core/fixed_block_free_list_manager_defines.svh =====
// Assertion macros for the free list manager.
`ifndef FIXED_BLOCK_FREE_LIST_MANAGER_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_MANAGER_DEFINES_SVH

`ifndef SYNTHESIS
`define FBLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FBLM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FBLM_ASSERT(lbl, prop, msg)
`define FBLM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/fblm_pkg.sv =====
// Shared types and codes for the free list manager.
package fblm_pkg;

    localparam int OP_W    = 2;
    localparam int SIZE_W  = 16;
    localparam int CELL_W  = 10;
    localparam int STAT_W  = 2;
    localparam int LIVE_W  = 11;
    localparam int BYTES_W = 32;
    localparam int OBJ_W   = 13;
    localparam int CCNT_W  = 11;
    localparam int CFG_DW  = 13;
    localparam int CFG_IW  = 1;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

    localparam logic [CFG_IW-1:0] REG_OBJECT_SIZE = 1'b0;
    localparam logic [CFG_IW-1:0] REG_CELL_COUNT  = 1'b1;

    localparam logic [OBJ_W-1:0]  OBJ_RST  = 13'd64;
    localparam logic [CCNT_W-1:0] CCNT_RST = 11'd1024;
    localparam logic [LIVE_W-1:0] LIVE_MAX = 11'd2047;

    typedef struct packed {
        logic [OBJ_W-1:0]  object_size;
        logic [CCNT_W-1:0] cell_count;
    } t_cfg;

endpackage

// ===== rtl/core/fblm_req_if.sv =====
// Request channel: opcode, allocation size and returned cell.
interface fblm_req_if;
    import fblm_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [SIZE_W-1:0] alloc_size;
    logic [CELL_W-1:0] free_cell;

    modport source (output valid, output opcode, output alloc_size, output free_cell,
                    input ready);
    modport sink   (input valid, input opcode, input alloc_size, input free_cell,
                    output ready);
endinterface

// ===== rtl/core/fblm_rsp_if.sv =====
// Response channel: status, granted cell, live count and byte total.
interface fblm_rsp_if;
    import fblm_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [CELL_W-1:0]  granted_cell;
    logic [LIVE_W-1:0]  live_count;
    logic [BYTES_W-1:0] used_bytes;

    modport source (output valid, output status, output granted_cell, output live_count,
                    output used_bytes, input ready);
    modport sink   (input valid, input status, input granted_cell, input live_count,
                    input used_bytes, output ready);
endinterface

// ===== rtl/core/fblm_link_ram.sv =====
// Link memory: one write port, one read port with registered data.
module fblm_link_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/fblm_cfg.sv =====
// Configuration registers: object size and cell count.
module fblm_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fblm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [fblm_pkg::CFG_DW-1:0] i_cfg_wdata,
    output fblm_pkg::t_cfg             o_cfg
);
    import fblm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OBJECT_SIZE: n_cfg.object_size = i_cfg_wdata[OBJ_W-1:0];
                REG_CELL_COUNT:  n_cfg.cell_count  = i_cfg_wdata[CCNT_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.object_size <= OBJ_RST;
            r_cfg.cell_count  <= CCNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== rtl/core/fixed_block_free_list_manager.sv =====
// Free list manager top level: request sequencer, pool state and accounting.
// Each request is accepted in IDLE, then executed in EXEC once the link RAM read of the
// chain head returns and the response register is free to take the result.
// No new request is taken until the current one executes and registers its response.
// Synchronous active-low reset empties the chain, zeroes counters; links stay unwritten.
`include "fixed_block_free_list_manager_defines.svh"

module fixed_block_free_list_manager #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fblm_req_if.sink                    i_req,
    fblm_rsp_if.source                  o_rsp,
    input  logic                        i_cfg_we,
    input  logic [fblm_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [fblm_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import fblm_pkg::*;

    localparam int LW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = (LW > LIVE_W) ? LW : LIVE_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    t_cfg cfg;

    logic               r_state;
    logic [OP_W-1:0]    r_op;
    logic [SIZE_W-1:0]  r_size;
    logic [CELL_W-1:0]  r_cell;
    logic [LW-1:0]      r_head;
    logic [LW-1:0]      r_fresh;
    logic [LIVE_W-1:0]  r_live;
    logic [BYTES_W-1:0] r_bytes;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic [CELL_W-1:0]  r_granted;

    logic [LW-1:0]      n_head;
    logic [LW-1:0]      n_fresh;
    logic [LIVE_W-1:0]  n_live;
    logic [BYTES_W-1:0] n_bytes;
    logic [STAT_W-1:0]  n_status;
    logic [CELL_W-1:0]  n_granted;

    logic               in_xfer;
    logic               exec_go;
    logic [CW-1:0]      cnt_ext;
    logic [CW-1:0]      eff;
    logic [CW-1:0]      cell_ext;
    logic [CW-1:0]      grant_ext;
    logic               head_null;
    logic               fresh_ok;
    logic               free_ok;
    logic [BYTES_W:0]   add_sum;
    logic               mem_we;
    logic [AW-1:0]      mem_raddr;
    logic [LW-1:0]      mem_rdata;

    fblm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign head_null = (r_head == NULL_LINK);
    assign mem_raddr = head_null ? '0 : r_head[AW-1:0];

    fblm_link_ram #(
        .DEPTH (POOL_DEPTH),
        .AW    (AW),
        .DW    (LW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (cell_ext[AW-1:0]),
        .i_wdata (r_head),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_xfer     = i_req.valid && i_req.ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    assign cnt_ext   = CW'(cfg.cell_count);
    assign eff       = (cnt_ext < CW'(POOL_DEPTH)) ? cnt_ext : CW'(POOL_DEPTH);
    assign cell_ext  = CW'(r_cell);
    assign fresh_ok  = (CW'(r_fresh) < eff);
    assign free_ok   = (cell_ext < eff);
    assign grant_ext = head_null ? CW'(r_fresh) : CW'(r_head);
    assign add_sum   = {1'b0, r_bytes} + (BYTES_W + 1)'(r_size);

    always_comb begin
        n_head    = r_head;
        n_fresh   = r_fresh;
        n_live    = r_live;
        n_bytes   = r_bytes;
        n_status  = ST_OK;
        n_granted = '0;
        mem_we    = 1'b0;
        unique case (r_op)
            OP_ALLOC: begin
                if (r_size == '0) begin
                    n_status = ST_BAD;
                end else if (!head_null || fresh_ok) begin
                    n_granted = grant_ext[CELL_W-1:0];
                    if (head_null) begin
                        n_fresh = r_fresh + 1'b1;
                    end else begin
                        n_head = mem_rdata;
                    end
                    if (r_live != LIVE_MAX) begin
                        n_live = r_live + 1'b1;
                    end
                    n_bytes = add_sum[BYTES_W] ? '1 : add_sum[BYTES_W-1:0];
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            OP_FREE: begin
                if (!free_ok) begin
                    n_status = ST_BAD;
                end else begin
                    mem_we = exec_go;
                    n_head = LW'(cell_ext);
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                    n_bytes = (r_bytes > BYTES_W'(cfg.object_size)) ?
                              r_bytes - BYTES_W'(cfg.object_size) : '0;
                end
            end
            OP_INIT: begin
                n_head  = NULL_LINK;
                n_fresh = '0;
                n_live  = '0;
                n_bytes = '0;
            end
            default: n_status = ST_BAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= NULL_LINK;
            r_fresh     <= '0;
            r_live      <= '0;
            r_bytes     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_xfer) r_state <= S_EXEC;
                S_EXEC: if (exec_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (exec_go) begin
                r_out_valid <= 1'b1;
                r_head      <= n_head;
                r_fresh     <= n_fresh;
                r_live      <= n_live;
                r_bytes     <= n_bytes;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= i_req.opcode;
            r_size <= i_req.alloc_size;
            r_cell <= i_req.free_cell;
        end
        if (exec_go) begin
            r_status  <= n_status;
            r_granted <= n_granted;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.granted_cell = r_granted;
    assign o_rsp.live_count   = r_live;
    assign o_rsp.used_bytes   = r_bytes;

    `FBLM_ASSERT_RST(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid),
                     "not idle after reset")
    `FBLM_ASSERT(a_accept_exec, in_xfer |=> (r_state == S_EXEC),
                 "accepted request not executed")
    `FBLM_ASSERT(a_head_range, (r_head <= NULL_LINK) && (r_fresh <= NULL_LINK),
                 "head or mark out of range")
    `FBLM_ASSERT(a_grant_zero, (r_out_valid && r_status != ST_OK) |-> (r_granted == '0),
                 "grant on failed request")

endmodule
